FILE: src/ics_pkg.sv
// ----------------------------------------------------------------------------
// ics_pkg
// Shared codes and the controller state type of the interval set coalescer.
// ----------------------------------------------------------------------------
package ics_pkg;

    localparam logic ACT_ADD  = 1'b0;
    localparam logic ACT_READ = 1'b1;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_DECIDE,
        ST_MV_RD,
        ST_MV_WR,
        ST_PUT,
        ST_RESP,
        ST_RD_RD,
        ST_RD_WAIT
    } ics_state_t;

endpackage

FILE: src/interval_set_coalescer.sv
// ----------------------------------------------------------------------------
// interval_set_coalescer
// Sorted table of disjoint closed intervals held in one RAM. An add beat
// merges a value into the table; a read beat streams out every interval.
//
//   channel | direction | payload
//   s_      | in        | action, value
//   m_      | out       | range_start, range_end, last, empty_res, dropped, count
//
// An add scans every stored interval through the registered RAM read port,
// then shifts the intervals that must move, then writes the merged interval.
// A read fetches each interval in turn through the registered RAM read port.
// One beat is worked on at a time; output stalls hold the controller.
// Reset empties the table at once; no clearing pass is needed.
// ----------------------------------------------------------------------------
module interval_set_coalescer #(
    parameter int MAX_INTERVALS = 32,
    parameter int VALUE_BITS    = 31
) (
    input  logic                                    aclk,
    input  logic                                    aresetn,
    input  logic                                    s_valid,
    output logic                                    s_ready,
    input  logic                                    s_action,
    input  logic [VALUE_BITS-1:0]                   s_value,
    output logic                                    m_valid,
    input  logic                                    m_ready,
    output logic [VALUE_BITS-1:0]                   m_range_start,
    output logic [VALUE_BITS-1:0]                   m_range_end,
    output logic                                    m_last,
    output logic                                    m_empty_res,
    output logic                                    m_dropped,
    output logic [$clog2(MAX_INTERVALS+1)-1:0]      m_count
);

    import ics_pkg::*;

    localparam int CW = $clog2(MAX_INTERVALS + 1);
    localparam int AW = (MAX_INTERVALS > 1) ? $clog2(MAX_INTERVALS) : 1;
    localparam int VB = VALUE_BITS;
    localparam logic [CW-1:0] MAX_CNT = CW'(MAX_INTERVALS);

    ics_state_t state_reg, state_next;

    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] nb_reg, nb_next;
    logic [CW-1:0] mg_reg, mg_next;
    logic [CW-1:0] idx_reg, idx_next;
    logic [VB-1:0] lo_reg, lo_next;
    logic [VB-1:0] hi_reg, hi_next;
    logic [VB-1:0] x_reg, x_next;
    logic          up_reg, up_next;
    logic          drop_reg, drop_next;
    logic          empty_reg, empty_next;

    logic          m_valid_reg, m_valid_next;
    logic [VB-1:0] m_start_reg, m_start_next;
    logic [VB-1:0] m_end_reg, m_end_next;
    logic          m_last_reg, m_last_next;
    logic          m_empty_reg, m_empty_next;
    logic          m_drop_reg, m_drop_next;
    logic [CW-1:0] m_count_reg, m_count_next;

    logic            ram_we, ram_re;
    logic [AW-1:0]   ram_waddr, ram_raddr;
    logic [2*VB-1:0] ram_wdata, ram_rdata;
    logic [VB-1:0]   rd_start, rd_end;
    logic            slot_free, push;
    logic            is_before, is_after;
    logic [CW-1:0]   idx_inc, idx_dec, dn_addr;

    ics_ram #(.WIDTH(2 * VB), .DEPTH(MAX_INTERVALS)) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign rd_start  = ram_rdata[2*VB-1:VB];
    assign rd_end    = ram_rdata[VB-1:0];
    assign slot_free = !m_valid_reg || m_ready;
    assign idx_inc   = idx_reg + CW'(1);
    assign idx_dec   = idx_reg - CW'(1);
    assign dn_addr   = idx_reg - mg_reg + CW'(1);
    assign is_before = ((VB+1)'(rd_end) + (VB+1)'(1)) < (VB+1)'(x_reg);
    assign is_after  = (VB+1)'(rd_start) > ((VB+1)'(x_reg) + (VB+1)'(1));

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_action == ACT_READ) begin
                        state_next = (n_reg == '0) ? ST_RESP : ST_RD_RD;
                    end else begin
                        state_next = (n_reg == '0) ? ST_DECIDE : ST_SCAN_RD;
                    end
                end
            end
            ST_SCAN_RD: state_next = ST_SCAN_EV;
            ST_SCAN_EV: state_next = (idx_inc == n_reg) ? ST_DECIDE : ST_SCAN_RD;
            ST_DECIDE: begin
                if (mg_reg == '0) begin
                    if (n_reg >= MAX_CNT) begin
                        state_next = ST_RESP;
                    end else begin
                        state_next = (n_reg > nb_reg) ? ST_MV_RD : ST_PUT;
                    end
                end else begin
                    state_next = (mg_reg > CW'(1) && nb_reg + mg_reg < n_reg) ?
                                 ST_MV_RD : ST_PUT;
                end
            end
            ST_MV_RD: state_next = ST_MV_WR;
            ST_MV_WR: begin
                if (up_reg) begin
                    state_next = (idx_reg == nb_reg) ? ST_PUT : ST_MV_RD;
                end else begin
                    state_next = (idx_inc == n_reg) ? ST_PUT : ST_MV_RD;
                end
            end
            ST_PUT:     state_next = ST_RESP;
            ST_RESP:    state_next = slot_free ? ST_IDLE : ST_RESP;
            ST_RD_RD:   state_next = ST_RD_WAIT;
            ST_RD_WAIT: begin
                if (slot_free) begin
                    state_next = (idx_inc == n_reg) ? ST_IDLE : ST_RD_RD;
                end
            end
            default:    state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready    = 1'b0;
        n_next     = n_reg;
        nb_next    = nb_reg;
        mg_next    = mg_reg;
        idx_next   = idx_reg;
        lo_next    = lo_reg;
        hi_next    = hi_reg;
        x_next     = x_reg;
        up_next    = up_reg;
        drop_next  = drop_reg;
        empty_next = empty_reg;
        ram_we     = 1'b0;
        ram_re     = 1'b0;
        ram_waddr  = idx_reg[AW-1:0];
        ram_raddr  = idx_reg[AW-1:0];
        ram_wdata  = ram_rdata;
        push         = 1'b0;
        m_start_next = '0;
        m_end_next   = '0;
        m_last_next  = 1'b1;
        m_empty_next = 1'b0;
        m_drop_next  = 1'b0;
        m_count_next = n_reg;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready    = 1'b1;
                idx_next   = '0;
                nb_next    = '0;
                mg_next    = '0;
                lo_next    = s_value;
                hi_next    = s_value;
                x_next     = s_value;
                drop_next  = 1'b0;
                empty_next = (s_action == ACT_READ);
            end
            ST_SCAN_RD: ram_re = 1'b1;
            ST_SCAN_EV: begin
                idx_next = idx_inc;
                if (is_before) begin
                    nb_next = idx_inc;
                end else if (!is_after) begin
                    mg_next = mg_reg + CW'(1);
                    if (rd_start < lo_reg) lo_next = rd_start;
                    if (rd_end > hi_reg) hi_next = rd_end;
                end
            end
            ST_DECIDE: begin
                up_next = (mg_reg == '0);
                if (mg_reg == '0) begin
                    drop_next = (n_reg >= MAX_CNT);
                    idx_next  = n_reg - CW'(1);
                end else begin
                    idx_next  = nb_reg + mg_reg;
                end
            end
            ST_MV_RD: ram_re = 1'b1;
            ST_MV_WR: begin
                ram_we = 1'b1;
                if (up_reg) begin
                    ram_waddr = idx_inc[AW-1:0];
                    idx_next  = idx_dec;
                end else begin
                    ram_waddr = dn_addr[AW-1:0];
                    idx_next  = idx_inc;
                end
            end
            ST_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = nb_reg[AW-1:0];
                ram_wdata = {lo_reg, hi_reg};
                n_next    = up_reg ? (n_reg + CW'(1)) : (n_reg - mg_reg + CW'(1));
            end
            ST_RESP: begin
                push         = slot_free;
                m_empty_next = empty_reg;
                m_drop_next  = drop_reg;
            end
            ST_RD_RD: ram_re = 1'b1;
            ST_RD_WAIT: begin
                push         = slot_free;
                m_start_next = rd_start;
                m_end_next   = rd_end;
                m_last_next  = (idx_inc == n_reg);
                if (slot_free) idx_next = idx_inc;
            end
            default: ;
        endcase
        m_valid_next = push ? 1'b1 : (m_ready ? 1'b0 : m_valid_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            n_reg       <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            n_reg       <= n_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        nb_reg    <= nb_next;
        mg_reg    <= mg_next;
        idx_reg   <= idx_next;
        lo_reg    <= lo_next;
        hi_reg    <= hi_next;
        x_reg     <= x_next;
        up_reg    <= up_next;
        drop_reg  <= drop_next;
        empty_reg <= empty_next;
        if (push) begin
            m_start_reg <= m_start_next;
            m_end_reg   <= m_end_next;
            m_last_reg  <= m_last_next;
            m_empty_reg <= m_empty_next;
            m_drop_reg  <= m_drop_next;
            m_count_reg <= m_count_next;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_range_start = m_start_reg;
    assign m_range_end   = m_end_reg;
    assign m_last        = m_last_reg;
    assign m_empty_res   = m_empty_reg;
    assign m_dropped     = m_drop_reg;
    assign m_count       = m_count_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        n_reg <= MAX_CNT) else $error("interval count exceeds table size");

    a_empty_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_empty_res |-> m_last && m_count == '0)
        else $error("empty read beat malformed");

    a_drop_full: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_dropped |-> m_count == MAX_CNT && m_last)
        else $error("drop flagged while table not full");

    a_no_accept_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second beat accepted while busy");

endmodule

FILE: src/ics_ram.sv
// ----------------------------------------------------------------------------
// ics_ram
// Simple dual-port RAM, one write port and one registered read port.
// ----------------------------------------------------------------------------
module ics_ram #(
    parameter int WIDTH = 62,
    parameter int DEPTH = 32
) (
    input  logic                                    aclk,
    input  logic                                    we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                        wdata,
    input  logic                                    re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                        rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: tb/interval_set_coalescer_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_set_coalescer_checker
// Watches both channels of the coalescer, keeps its own sorted interval
// table, and compares every result beat against the oldest expected beat.
// ----------------------------------------------------------------------------
module interval_set_coalescer_checker #(
    parameter int MAX_INTERVALS = 32,
    parameter int VALUE_BITS    = 31
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    input  logic                               s_ready,
    input  logic                               s_action,
    input  logic [VALUE_BITS-1:0]              s_value,
    input  logic                               m_valid,
    input  logic                               m_ready,
    input  logic [VALUE_BITS-1:0]              m_range_start,
    input  logic [VALUE_BITS-1:0]              m_range_end,
    input  logic                               m_last,
    input  logic                               m_empty_res,
    input  logic                               m_dropped,
    input  logic [$clog2(MAX_INTERVALS+1)-1:0] m_count,
    output int                                 errors,
    output int                                 pending,
    output int                                 reads_seen,
    output int                                 drops_seen
);
    import ics_pkg::*;

    localparam int CW = $clog2(MAX_INTERVALS+1);

    typedef struct packed {
        logic [VALUE_BITS-1:0] lo;
        logic [VALUE_BITS-1:0] hi;
        logic                  last;
        logic                  empty;
        logic                  drop;
        logic [CW-1:0]         cnt;
    } beat_t;

    logic [VALUE_BITS-1:0] iv_lo [MAX_INTERVALS];
    logic [VALUE_BITS-1:0] iv_hi [MAX_INTERVALS];
    int                    iv_n;
    beat_t                 want_q [$];

    assign pending = want_q.size();

    function automatic beat_t mk(logic [VALUE_BITS-1:0] lo, logic [VALUE_BITS-1:0] hi,
                                 logic l, logic e, logic d, int c);
        beat_t b;
        b.lo = lo; b.hi = hi; b.last = l; b.empty = e; b.drop = d; b.cnt = CW'(c);
        return b;
    endfunction

    task automatic add_want(input beat_t b);
        want_q.insert(want_q.size(), b);
    endtask

    task automatic coalesce(input logic act, input logic [VALUE_BITS-1:0] v);
        longint x, lo, hi;
        int nb, nm, k;
        logic [VALUE_BITS-1:0] ns [MAX_INTERVALS+1];
        logic [VALUE_BITS-1:0] ne [MAX_INTERVALS+1];
        x = v; lo = x; hi = x; nb = 0; nm = 0; k = 0;
        if (act == ACT_READ) begin
            reads_seen++;
            if (iv_n == 0) add_want(mk('0, '0, 1, 1, 0, 0));
            for (int i = 0; i < iv_n; i++)
                add_want(mk(iv_lo[i], iv_hi[i], i == iv_n-1, 0, 0, iv_n));
            return;
        end
        for (int i = 0; i < iv_n; i++) begin
            if (longint'(iv_hi[i]) + 1 < x) nb = i + 1;
            else if (longint'(iv_lo[i]) > x + 1) ;
            else begin
                nm++;
                if (iv_lo[i] < lo) lo = iv_lo[i];
                if (iv_hi[i] > hi) hi = iv_hi[i];
            end
        end
        if (nm == 0 && iv_n >= MAX_INTERVALS) begin
            drops_seen++;
            add_want(mk('0, '0, 1, 0, 1, iv_n));
            return;
        end
        for (int i = 0; i < nb; i++) begin
            ns[k] = iv_lo[i]; ne[k] = iv_hi[i]; k++;
        end
        ns[k] = lo[VALUE_BITS-1:0]; ne[k] = hi[VALUE_BITS-1:0]; k++;
        for (int i = nb + nm; i < iv_n; i++) begin
            ns[k] = iv_lo[i]; ne[k] = iv_hi[i]; k++;
        end
        for (int i = 0; i < k; i++) begin
            iv_lo[i] = ns[i]; iv_hi[i] = ne[i];
        end
        iv_n = k;
        add_want(mk('0, '0, 1, 0, 0, iv_n));
    endtask

    always @(posedge aclk) begin
        beat_t got, exp;
        if (!aresetn) begin
            iv_n = 0; errors = 0; reads_seen = 0; drops_seen = 0;
            want_q.delete();
        end else begin
            if (m_valid && m_ready) begin
                got = {m_range_start, m_range_end, m_last, m_empty_res, m_dropped, m_count};
                if (want_q.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result beat %p", $realtime, got);
                end else begin
                    exp = want_q.pop_front();
                    if (got !== exp) begin
                        errors++;
                        $display("%0t: mismatch expected %p actual %p", $realtime, exp, got);
                    end
                end
            end
            if (s_valid && s_ready) coalesce(s_action, s_value);
        end
    end
endmodule

FILE: tb/interval_set_coalescer_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// interval_set_coalescer_tb
// Drives add and read beats with random gaps and output stalls, starting
// with directed corner cases (top and bottom values, bridging, full table).
// ----------------------------------------------------------------------------
module interval_set_coalescer_tb;
    import ics_pkg::*;

    localparam int MAXI = 32;
    localparam int VB   = 31;
    localparam int LIMIT = 2000000;

    logic aclk = 0, aresetn = 0;
    logic s_valid = 0, s_ready, s_action = 0;
    logic [VB-1:0] s_value = '0;
    logic m_valid, m_ready = 0, m_last, m_empty_res, m_dropped;
    logic [VB-1:0] m_range_start, m_range_end;
    logic [$clog2(MAXI+1)-1:0] m_count;
    int errors, pending, reads_seen, drops_seen, cycles = 0, sent = 0;
    bit calm = 0;

    always begin
        #4 aclk = 1;
        #4 aclk = 0;
    end

    interval_set_coalescer #(.MAX_INTERVALS(MAXI), .VALUE_BITS(VB)) DUT (.*);

    interval_set_coalescer_checker #(.MAX_INTERVALS(MAXI), .VALUE_BITS(VB)) u_chk (.*);

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        m_ready <= calm || ($urandom_range(99) >= 31);
        if (cycles > LIMIT) begin
            $display("FAIL interval_set_coalescer");
            $finish;
        end
    end

    task automatic send(input logic act, input logic [VB-1:0] v);
        while (!calm && $urandom_range(99) < 31) begin
            s_valid <= 0;
            @(posedge aclk);
        end
        s_valid <= 1; s_action <= act; s_value <= v;
        do @(posedge aclk); while (!s_ready);
        sent++;
    endtask

    initial begin
        repeat (8) @(posedge aclk);
        aresetn <= 1;
        @(posedge aclk);
        send(ACT_READ, '1);
        send(ACT_ADD, '1);
        send(ACT_ADD, '0);
        send(ACT_ADD, '1);
        send(ACT_ADD, 31'h7FFF_FFFD);
        send(ACT_ADD, 31'h7FFF_FFFE);
        send(ACT_ADD, VB'(2));
        send(ACT_ADD, VB'(1));
        send(ACT_ADD, 31'h2AAA_AAAA);
        send(ACT_ADD, 31'h5555_5555);
        send(ACT_READ, '0);
        for (int i = 0; i < 32; i++) send(ACT_ADD, 31'(100 + 3 * i));
        send(ACT_ADD, 31'h1234_5678);
        send(ACT_ADD, VB'(101));
        send(ACT_READ, 31'h5555_5555);
        for (int i = 0; i < 53; i++) begin
            if (i == 20) calm = 1;
            if (i == 40) calm = 0;
            if ($urandom_range(9) < 2) send(ACT_READ, VB'($urandom));
            else if ($urandom_range(9) < 7) send(ACT_ADD, VB'($urandom_range(400)));
            else if ($urandom_range(1)) send(ACT_ADD, VB'($urandom_range(130)) + 31'h7FFF_FF70);
            else send(ACT_ADD, VB'($urandom));
        end
        send(ACT_READ, '0);
        s_valid <= 0;
        while (pending != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        $display("Sent %0d beats: %0d reads, %0d dropped adds.", sent, reads_seen, drops_seen);
        if (errors == 0 && pending == 0) $display("PASS interval_set_coalescer");
        else $display("FAIL interval_set_coalescer");
        $finish;
    end
endmodule

FILE: interval_set_coalescer.f
src/ics_pkg.sv
src/ics_ram.sv
src/interval_set_coalescer.sv
tb/interval_set_coalescer_checker.sv
tb/interval_set_coalescer_tb.sv
